>>> rtl/ising_pkg.sv
package ising_pkg;

  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;
  localparam int ROW_W    = $clog2(MAX_SIDE);
  localparam int K_W      = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int SITE_W   = 12;
  localparam int NSITE_W  = SITE_W + 1;
  localparam int CMD_W    = 2;
  localparam int FRAC_W   = 32;
  localparam int ENERGY_W = 15;
  localparam int MAG_W    = 14;
  localparam int WALL_W   = 13;
  localparam int CNT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PC_W     = 5;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FLIP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOUR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EIGHT = 2'd2;

  localparam logic [CNT_W-1:0] ALIGN_THREE = 3'd3;
  localparam logic [CNT_W-1:0] ALIGN_FOUR  = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DECIDE,
    OP_WRITE,
    OP_EMIT,
    OP_SCAN_INIT,
    OP_SCAN_ACC,
    OP_SCAN_COMMIT
  } op_e;

  typedef enum logic [2:0] {
    ADDR_SITE,
    ADDR_SELF,
    ADDR_RIGHT,
    ADDR_LEFT,
    ADDR_UP,
    ADDR_DOWN
  } addr_sel_e;

  typedef enum logic [1:0] {
    LAT_NONE,
    LAT_S,
    LAT_N,
    LAT_SR
  } latch_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_MEASURE,
    COND_SKIP,
    COND_WRITE,
    COND_DIV_MORE,
    COND_SCAN_MORE
  } cond_e;

  typedef struct packed {
    op_e             op;
    addr_sel_e       addr;
    logic            rd;
    latch_e          lat;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] ST_MEASURE   = 5'd1;
  localparam logic [PC_W-1:0] ST_SKIP      = 5'd2;
  localparam logic [PC_W-1:0] ST_ISWRITE   = 5'd3;
  localparam logic [PC_W-1:0] ST_DIV_INIT  = 5'd4;
  localparam logic [PC_W-1:0] ST_DIV_STEP  = 5'd5;
  localparam logic [PC_W-1:0] ST_RD_SELF   = 5'd6;
  localparam logic [PC_W-1:0] ST_RD_RIGHT  = 5'd7;
  localparam logic [PC_W-1:0] ST_RD_LEFT   = 5'd8;
  localparam logic [PC_W-1:0] ST_RD_UP     = 5'd9;
  localparam logic [PC_W-1:0] ST_RD_DOWN   = 5'd10;
  localparam logic [PC_W-1:0] ST_LAST_N    = 5'd11;
  localparam logic [PC_W-1:0] ST_DECIDE    = 5'd12;
  localparam logic [PC_W-1:0] ST_WRITE     = 5'd13;
  localparam logic [PC_W-1:0] ST_REPORT    = 5'd14;
  localparam logic [PC_W-1:0] ST_EMIT      = 5'd15;
  localparam logic [PC_W-1:0] ST_SCAN_INIT = 5'd16;
  localparam logic [PC_W-1:0] ST_SCAN_SELF = 5'd17;
  localparam logic [PC_W-1:0] ST_SCAN_RGT  = 5'd18;
  localparam logic [PC_W-1:0] ST_SCAN_DOWN = 5'd19;
  localparam logic [PC_W-1:0] ST_SCAN_ACC  = 5'd20;
  localparam logic [PC_W-1:0] ST_COMMIT    = 5'd21;

  function automatic ctrl_t cw(input op_e op, input addr_sel_e addr, input logic rd,
                               input latch_e lat, input cond_e cond,
                               input logic [PC_W-1:0] target);
    ctrl_t c;
    c.op     = op;
    c.addr   = addr;
    c.rd     = rd;
    c.lat    = lat;
    c.cond   = cond;
    c.target = target;
    return c;
  endfunction

  // microcode program
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      ST_IDLE:      c = cw(OP_IDLE, ADDR_SITE, 1'b0, LAT_NONE, COND_NEXT, ST_IDLE);
      ST_MEASURE:   c = cw(OP_NOP, ADDR_SITE, 1'b0, LAT_NONE, COND_MEASURE, ST_SCAN_INIT);
      ST_SKIP:      c = cw(OP_NOP, ADDR_SITE, 1'b0, LAT_NONE, COND_SKIP, ST_REPORT);
      ST_ISWRITE:   c = cw(OP_NOP, ADDR_SITE, 1'b0, LAT_NONE, COND_WRITE, ST_WRITE);
      ST_DIV_INIT:  c = cw(OP_DIV_INIT, ADDR_SITE, 1'b0, LAT_NONE, COND_NEXT, ST_IDLE);
      ST_DIV_STEP:  c = cw(OP_DIV_STEP, ADDR_SITE, 1'b0, LAT_NONE, COND_DIV_MORE,
                           ST_DIV_STEP);
      ST_RD_SELF:   c = cw(OP_NOP, ADDR_SELF, 1'b1, LAT_NONE, COND_NEXT, ST_IDLE);
      ST_RD_RIGHT:  c = cw(OP_NOP, ADDR_RIGHT, 1'b1, LAT_S, COND_NEXT, ST_IDLE);
      ST_RD_LEFT:   c = cw(OP_NOP, ADDR_LEFT, 1'b1, LAT_N, COND_NEXT, ST_IDLE);
      ST_RD_UP:     c = cw(OP_NOP, ADDR_UP, 1'b1, LAT_N, COND_NEXT, ST_IDLE);
      ST_RD_DOWN:   c = cw(OP_NOP, ADDR_DOWN, 1'b1, LAT_N, COND_NEXT, ST_IDLE);
      ST_LAST_N:    c = cw(OP_NOP, ADDR_SELF, 1'b0, LAT_N, COND_NEXT, ST_IDLE);
      ST_DECIDE:    c = cw(OP_DECIDE, ADDR_SELF, 1'b0, LAT_NONE, COND_ALWAYS, ST_REPORT);
      ST_WRITE:     c = cw(OP_WRITE, ADDR_SITE, 1'b0, LAT_NONE, COND_NEXT, ST_IDLE);
      ST_REPORT:    c = cw(OP_NOP, ADDR_SITE, 1'b1, LAT_NONE, COND_NEXT, ST_IDLE);
      ST_EMIT:      c = cw(OP_EMIT, ADDR_SITE, 1'b0, LAT_NONE, COND_ALWAYS, ST_IDLE);
      ST_SCAN_INIT: c = cw(OP_SCAN_INIT, ADDR_SELF, 1'b0, LAT_NONE, COND_NEXT, ST_IDLE);
      ST_SCAN_SELF: c = cw(OP_NOP, ADDR_SELF, 1'b1, LAT_NONE, COND_NEXT, ST_IDLE);
      ST_SCAN_RGT:  c = cw(OP_NOP, ADDR_RIGHT, 1'b1, LAT_S, COND_NEXT, ST_IDLE);
      ST_SCAN_DOWN: c = cw(OP_NOP, ADDR_DOWN, 1'b1, LAT_SR, COND_NEXT, ST_IDLE);
      ST_SCAN_ACC:  c = cw(OP_SCAN_ACC, ADDR_SELF, 1'b0, LAT_NONE, COND_SCAN_MORE,
                           ST_SCAN_SELF);
      ST_COMMIT:    c = cw(OP_SCAN_COMMIT, ADDR_SITE, 1'b0, LAT_NONE, COND_ALWAYS,
                           ST_REPORT);
      default:      c = cw(OP_NOP, ADDR_SITE, 1'b0, LAT_NONE, COND_ALWAYS, ST_IDLE);
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ising_cmd_if.sv
interface ising_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [ising_pkg::CMD_W-1:0]    command;
  logic [ising_pkg::SITE_W-1:0]   site;
  logic                           spin_value;
  logic [ising_pkg::FRAC_W-1:0]   uniform;

  modport source (output valid, output command, output site, output spin_value,
                  output uniform, input ready);
  modport sink (input valid, input command, input site, input spin_value,
                input uniform, output ready);
endinterface

>>> rtl/ising_res_if.sv
interface ising_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 accepted;
  logic                                 spin_now;
  logic signed [ising_pkg::ENERGY_W-1:0] energy;
  logic signed [ising_pkg::MAG_W-1:0]    magnetization;
  logic [ising_pkg::WALL_W-1:0]          right_walls;
  logic [ising_pkg::WALL_W-1:0]          down_walls;

  modport source (output valid, output accepted, output spin_now, output energy,
                  output magnetization, output right_walls, output down_walls,
                  input ready);
  modport sink (input valid, input accepted, input spin_now, input energy,
                input magnetization, input right_walls, input down_walls,
                output ready);
endinterface

>>> rtl/ising_metropolis_lattice_engine.sv
// Periodic square Ising lattice with single-spin-flip Metropolis updates.
// cmd_i (valid/ready) carries one command beat: write a spin, make one flip
// attempt at a site, or measure the lattice by a full scan. res_o carries one
// result beat per command: flip taken, spin at the site, energy, and the
// magnetization and wall counts of the latest scan.
// The cfg port writes side length and the two acceptance levels, one register per
// cycle; the user must write them only while no command is in flight, which the block does not enforce.
// A microcoded sequencer walks one command at a time through a single-port
// spin memory with registered read data. A write stores the spin; a site outside
// the lattice or an unknown command goes straight to the result. A flip attempt
// runs six restoring divide steps that split the site into row and column, five
// reads, a write-back when the flip is taken and one read of the result spin. A
// measure reads each site with its right and down neighbours and accumulates.
// cmd_i is ready only while the sequencer waits at its idle step, so a command
// holds the sequencer until its emit step is done.
// The result register frees the sequencer: the next command is taken while a
// result still waits; that command stalls at its emit step until res_o drains.
// Reset clears energy, magnetization and wall counts, sets side 64 and both
// levels 0; the spin memory is not cleared and must be written before use.
module ising_metropolis_lattice_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ising_cmd_if.sink                           cmd_i,
  ising_res_if.source                         res_o,
  input  logic                                cfg_we_i,
  input  logic [ising_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ising_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int SW  = ising_pkg::SITE_W;
  localparam int NW  = ising_pkg::NSITE_W;
  localparam int LW  = ising_pkg::SIDE_W;
  localparam int RW  = ising_pkg::ROW_W;
  localparam int KW  = ising_pkg::K_W;
  localparam int EW  = ising_pkg::ENERGY_W;
  localparam int MW  = ising_pkg::MAG_W;
  localparam int WW  = ising_pkg::WALL_W;
  localparam int CW_ = ising_pkg::CNT_W;
  localparam int FW  = ising_pkg::FRAC_W;
  localparam int DEPTH = ising_pkg::MAX_SIDE * ising_pkg::MAX_SIDE;

  // configuration
  logic [LW-1:0] side_q;
  logic [FW-1:0] level_four_q, level_eight_q;

  // sequencer
  logic [ising_pkg::PC_W-1:0] pc_q, pc_d;
  ising_pkg::ctrl_t           ctrl;
  logic                       stall, jump;

  // command holding
  logic [ising_pkg::CMD_W-1:0] cmd_q;
  logic [SW-1:0]               site_q;
  logic                        spin_value_q;
  logic [FW-1:0]               uniform_q;

  // datapath
  logic [SW-1:0]  idx_q, col_q;
  logic [RW-1:0]  row_q;
  logic [KW-1:0]  k_q;
  logic           s_q, sr_q;
  logic [CW_-1:0] align_q;
  logic           accepted_q;
  logic [WW-1:0]  ones_q, rw_acc_q, dw_acc_q;

  // architectural state
  logic [EW-1:0]  energy_q;
  logic [MW-1:0]  mag_q;
  logic [WW-1:0]  right_walls_q, down_walls_q;

  // spin memory
  logic           spin_mem_q [DEPTH];
  logic           rd_data_q;
  logic [SW-1:0]  mem_addr;
  logic           mem_we, mem_wdata;

  // result register
  logic           res_valid_q;
  logic           res_accepted_q, res_spin_q;
  logic [EW-1:0]  res_energy_q;
  logic [MW-1:0]  res_mag_q;
  logic [WW-1:0]  res_rw_q, res_dw_q;

  // derived
  logic [LW-1:0]   side_use;
  logic [2*LW-1:0] side_sq;
  logic [NW-1:0]   n_sites;
  logic            in_lattice;
  logic [SW-1:0]   side_ext, side_m1, n_minus_side, last_idx;
  logic            col_last, col_first, row_last, row_first;
  logic [SW-1:0]   addr_right, addr_left, addr_up, addr_down;
  logic [NW-1:0]   div_trial;
  logic            div_fit;
  logic            take;
  logic [EW-1:0]   delta_e;
  logic [EW-1:0]   wall_sum;

  assign side_use = (side_q < ising_pkg::SIDE_MIN) ? ising_pkg::SIDE_MIN :
                    (side_q > ising_pkg::SIDE_RESET) ? ising_pkg::SIDE_RESET : side_q;
  assign side_sq    = (2*LW)'(side_use) * (2*LW)'(side_use);
  assign n_sites    = side_sq[NW-1:0];
  assign in_lattice = ({1'b0, site_q} < n_sites);

  assign side_ext     = SW'(side_use);
  assign side_m1      = side_ext - SW'(1);
  assign n_minus_side = n_sites[SW-1:0] - side_ext;
  assign last_idx     = n_sites[SW-1:0] - SW'(1);

  assign col_last  = (col_q == side_m1);
  assign col_first = (col_q == '0);
  assign row_last  = (LW'(row_q) == side_use - LW'(1));
  assign row_first = (row_q == '0);

  // wraparound neighbours
  assign addr_right = col_last  ? idx_q - side_m1      : idx_q + SW'(1);
  assign addr_left  = col_first ? idx_q + side_m1      : idx_q - SW'(1);
  assign addr_up    = row_first ? idx_q + n_minus_side : idx_q - side_ext;
  assign addr_down  = row_last  ? idx_q - n_minus_side : idx_q + side_ext;

  assign div_trial = NW'(side_use) << k_q;
  assign div_fit   = ({1'b0, col_q} >= div_trial);

  assign take = (align_q < ising_pkg::ALIGN_THREE) ||
                ((align_q == ising_pkg::ALIGN_THREE) && (uniform_q < level_four_q)) ||
                ((align_q == ising_pkg::ALIGN_FOUR) && (uniform_q < level_eight_q));
  // dE = 4 * aligned neighbours - 8
  assign delta_e  = EW'({align_q, 2'b00}) - EW'(8);
  assign wall_sum = EW'(rw_acc_q) + EW'(dw_acc_q);

  assign ctrl  = ising_pkg::ucode(pc_q);
  assign stall = ((ctrl.op == ising_pkg::OP_IDLE) && !cmd_i.valid) ||
                 ((ctrl.op == ising_pkg::OP_EMIT) && res_valid_q && !res_o.ready);

  always_comb begin
    case (ctrl.cond)
      ising_pkg::COND_NEXT:      jump = 1'b0;
      ising_pkg::COND_ALWAYS:    jump = 1'b1;
      ising_pkg::COND_MEASURE:   jump = (cmd_q == ising_pkg::CMD_MEASURE);
      ising_pkg::COND_SKIP:      jump = !(((cmd_q == ising_pkg::CMD_WRITE) ||
                                           (cmd_q == ising_pkg::CMD_FLIP)) && in_lattice);
      ising_pkg::COND_WRITE:     jump = (cmd_q == ising_pkg::CMD_WRITE);
      ising_pkg::COND_DIV_MORE:  jump = (k_q != '0);
      ising_pkg::COND_SCAN_MORE: jump = (idx_q != last_idx);
      default:                   jump = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + ising_pkg::PC_W'(1);
    end
  end

  always_comb begin
    case (ctrl.addr)
      ising_pkg::ADDR_SITE:  mem_addr = site_q;
      ising_pkg::ADDR_SELF:  mem_addr = idx_q;
      ising_pkg::ADDR_RIGHT: mem_addr = addr_right;
      ising_pkg::ADDR_LEFT:  mem_addr = addr_left;
      ising_pkg::ADDR_UP:    mem_addr = addr_up;
      ising_pkg::ADDR_DOWN:  mem_addr = addr_down;
      default:               mem_addr = site_q;
    endcase
  end

  assign mem_we    = (ctrl.op == ising_pkg::OP_WRITE) ||
                     ((ctrl.op == ising_pkg::OP_DECIDE) && take);
  assign mem_wdata = (ctrl.op == ising_pkg::OP_WRITE) ? spin_value_q : !s_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      spin_mem_q[mem_addr] <= mem_wdata;
    end
    if (ctrl.rd) begin
      rd_data_q <= spin_mem_q[mem_addr];
    end
  end

  assign cmd_i.ready = (ctrl.op == ising_pkg::OP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= ising_pkg::ST_IDLE;
      side_q        <= ising_pkg::SIDE_RESET;
      level_four_q  <= '0;
      level_eight_q <= '0;
      energy_q      <= '0;
      mag_q         <= '0;
      right_walls_q <= '0;
      down_walls_q  <= '0;
      res_valid_q   <= 1'b0;
      accepted_q    <= 1'b0;
    end else begin
      pc_q <= pc_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          ising_pkg::REG_SIDE:  side_q        <= cfg_data_i[LW-1:0];
          ising_pkg::REG_FOUR:  level_four_q  <= cfg_data_i[FW-1:0];
          ising_pkg::REG_EIGHT: level_eight_q <= cfg_data_i[FW-1:0];
          default: ;
        endcase
      end

      if ((ctrl.op == ising_pkg::OP_IDLE) && cmd_i.valid) begin
        accepted_q <= 1'b0;
      end

      if ((ctrl.op == ising_pkg::OP_DECIDE) && take) begin
        accepted_q <= 1'b1;
        energy_q   <= energy_q + delta_e;
      end

      if (ctrl.op == ising_pkg::OP_SCAN_COMMIT) begin
        energy_q      <= {wall_sum[EW-2:0], 1'b0} - {1'b0, n_sites, 1'b0};
        mag_q         <= {ones_q, 1'b0} - MW'(n_sites);
        right_walls_q <= rw_acc_q;
        down_walls_q  <= dw_acc_q;
      end

      if ((ctrl.op == ising_pkg::OP_EMIT) && !stall) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if ((ctrl.op == ising_pkg::OP_IDLE) && cmd_i.valid) begin
      cmd_q        <= cmd_i.command;
      site_q       <= cmd_i.site;
      spin_value_q <= cmd_i.spin_value;
      uniform_q    <= cmd_i.uniform;
    end

    case (ctrl.op)
      ising_pkg::OP_DIV_INIT: begin
        idx_q   <= site_q;
        col_q   <= site_q;
        row_q   <= '0;
        k_q     <= KW'(RW - 1);
        align_q <= '0;
      end
      ising_pkg::OP_DIV_STEP: begin
        if (div_fit) begin
          col_q      <= col_q - div_trial[SW-1:0];
          row_q[k_q] <= 1'b1;
        end
        k_q <= k_q - KW'(1);
      end
      ising_pkg::OP_SCAN_INIT: begin
        idx_q    <= '0;
        col_q    <= '0;
        row_q    <= '0;
        ones_q   <= '0;
        rw_acc_q <= '0;
        dw_acc_q <= '0;
      end
      ising_pkg::OP_SCAN_ACC: begin
        ones_q   <= ones_q + WW'(s_q);
        rw_acc_q <= rw_acc_q + WW'(s_q ^ sr_q);
        dw_acc_q <= dw_acc_q + WW'(s_q ^ rd_data_q);
        idx_q    <= idx_q + SW'(1);
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + SW'(1);
        end
      end
      default: ;
    endcase

    case (ctrl.lat)
      ising_pkg::LAT_S:  s_q     <= rd_data_q;
      ising_pkg::LAT_N:  align_q <= align_q + CW_'(rd_data_q == s_q);
      ising_pkg::LAT_SR: sr_q    <= rd_data_q;
      default: ;
    endcase

    if ((ctrl.op == ising_pkg::OP_EMIT) && !stall) begin
      res_accepted_q <= accepted_q;
      res_spin_q     <= in_lattice && rd_data_q;
      res_energy_q   <= energy_q;
      res_mag_q      <= mag_q;
      res_rw_q       <= right_walls_q;
      res_dw_q       <= down_walls_q;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.accepted      = res_accepted_q;
  assign res_o.spin_now      = res_spin_q;
  assign res_o.energy        = res_energy_q;
  assign res_o.magnetization = res_mag_q;
  assign res_o.right_walls   = res_rw_q;
  assign res_o.down_walls    = res_dw_q;

endmodule

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE   = ising_pkg::MAX_SIDE;
  localparam int CMD_W      = ising_pkg::CMD_W;
  localparam int SITE_W     = ising_pkg::SITE_W;
  localparam int FRAC_W     = ising_pkg::FRAC_W;
  localparam int ENERGY_W   = ising_pkg::ENERGY_W;
  localparam int MAG_W      = ising_pkg::MAG_W;
  localparam int WALL_W     = ising_pkg::WALL_W;
  localparam int SIDE_W     = ising_pkg::SIDE_W;
  localparam int CFG_IDX_W  = ising_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = ising_pkg::CFG_DATA_W;

  localparam int HALF_PERIOD = 6;
  localparam int NSITES = MAX_SIDE * MAX_SIDE;
  localparam logic [CMD_W-1:0] CMD_OTHER = 2'd3;

  typedef struct packed {
    logic                       accepted;
    logic                       spin_now;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [MAG_W-1:0]    magnetization;
    logic [WALL_W-1:0]          right_walls;
    logic [WALL_W-1:0]          down_walls;
  } obs_t;

  typedef struct {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CMD_W-1:0]     cmd;
    logic [SITE_W-1:0]    site;
    logic                 spin;
    logic [FRAC_W-1:0]    word;
    logic                 fixed;
    obs_t                 want;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ising_cmd_if cmd_bus ();
  ising_res_if res_bus ();

  ising_metropolis_lattice_engine i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_i      (cmd_bus),
    .res_o      (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // lattice predictor state
  logic                       lattice_bits [NSITES];
  bit                         written_map [NSITES];
  logic [SIDE_W-1:0]          side_reg;
  logic [FRAC_W-1:0]          level_four;
  logic [FRAC_W-1:0]          level_eight;
  logic signed [ENERGY_W-1:0] energy_acc;
  logic signed [MAG_W-1:0]    mag_acc;
  logic [WALL_W-1:0]          rwall_acc;
  logic [WALL_W-1:0]          dwall_acc;

  obs_t  pending_results [$];
  drow_t stim_rows [$];
  int    mismatch_count = 0;
  int    burst_left = 0;

  function automatic int side_in_use();
    int s;
    s = side_reg;
    if (s < 2) s = 2;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  function automatic int spin_pm(int idx);
    return lattice_bits[idx] ? 1 : -1;
  endfunction

  function automatic obs_t step_lattice(logic [CMD_W-1:0] cmd, logic [SITE_W-1:0] site,
                                        logic spin, logic [FRAC_W-1:0] uni);
    obs_t r;
    int   side, row, col, s, nsum, de, i, sr, sd, bonds, mag, rw, dw;
    logic in_lattice, take;
    side = side_in_use();
    in_lattice = int'(site) < side * side;
    row = int'(site) / side;
    col = int'(site) % side;
    r = '0;
    case (cmd)
      ising_pkg::CMD_WRITE: begin
        if (in_lattice) begin
          lattice_bits[site] = spin;
          written_map[site] = 1'b1;
        end
      end
      ising_pkg::CMD_FLIP: begin
        if (in_lattice) begin
          s = spin_pm(site);
          nsum = spin_pm(row * side + (col + 1) % side)
               + spin_pm(row * side + (col + side - 1) % side)
               + spin_pm(((row + side - 1) % side) * side + col)
               + spin_pm(((row + 1) % side) * side + col);
          de = 2 * s * nsum;
          if (de <= 0) take = 1'b1;
          else if (de == 4) take = uni < level_four;
          else take = uni < level_eight;
          if (take) begin
            lattice_bits[site] = ~lattice_bits[site];
            energy_acc = energy_acc + ENERGY_W'(de);
            r.accepted = 1'b1;
          end
        end
      end
      ising_pkg::CMD_MEASURE: begin
        bonds = 0;
        mag = 0;
        rw = 0;
        dw = 0;
        for (i = 0; i < side * side; i++) begin
          s = spin_pm(i);
          sr = spin_pm((i / side) * side + (i % side + 1) % side);
          sd = spin_pm(((i / side + 1) % side) * side + i % side);
          bonds += s * sr + s * sd;
          mag += s;
          if (s != sr) rw++;
          if (s != sd) dw++;
        end
        energy_acc = ENERGY_W'(-bonds);
        mag_acc = MAG_W'(mag);
        rwall_acc = WALL_W'(rw);
        dwall_acc = WALL_W'(dw);
      end
      default: ;
    endcase
    r.spin_now = in_lattice ? lattice_bits[site] : 1'b0;
    r.energy = energy_acc;
    r.magnetization = mag_acc;
    r.right_walls = rwall_acc;
    r.down_walls = dwall_acc;
    return r;
  endfunction

  function automatic logic [FRAC_W-1:0] pick_uniform();
    logic [FRAC_W-1:0] lvl, u;
    lvl = $urandom_range(0, 1) ? level_four : level_eight;
    case ($urandom_range(0, 5))
      0: u = lvl;
      1: u = lvl - 1;
      2: u = lvl + 1;
      3: u = $urandom_range(0, 1) ? '0 : '1;
      default: u = $urandom;
    endcase
    return u;
  endfunction

  function automatic drow_t cmd_row(logic [CMD_W-1:0] c, int s, logic v,
                                    logic [FRAC_W-1:0] w);
    drow_t r;
    r.is_reg = 1'b0;
    r.reg_idx = ising_pkg::REG_SIDE;
    r.cmd = c;
    r.site = SITE_W'(s);
    r.spin = v;
    r.word = w;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // stats still at reset, only the spin differs
  function automatic drow_t fixed_row(logic [CMD_W-1:0] c, int s, logic v,
                                      logic [FRAC_W-1:0] w, logic want_spin);
    drow_t r;
    r = cmd_row(c, s, v, w);
    r.fixed = 1'b1;
    r.want.spin_now = want_spin;
    return r;
  endfunction

  function automatic drow_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drow_t r;
    r = cmd_row(ising_pkg::CMD_WRITE, 0, 1'b0, data);
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    return r;
  endfunction

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [SITE_W-1:0] site, logic spin,
                          logic [FRAC_W-1:0] uni, bit use_fixed, obs_t fixed);
    obs_t calc;
    @(negedge clk);
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= cmd;
    cmd_bus.site <= site;
    cmd_bus.spin_value <= spin;
    cmd_bus.uniform <= uni;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    calc = step_lattice(cmd, site, spin, uni);
    pending_results.push_back(use_fixed ? fixed : calc);
  endtask

  task automatic settle();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      ising_pkg::REG_SIDE:  side_reg = data[SIDE_W-1:0];
      ising_pkg::REG_FOUR:  level_four = data;
      ising_pkg::REG_EIGHT: level_eight = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int side_cfg, logic [FRAC_W-1:0] four, logic [FRAC_W-1:0] eight,
                           int count);
    int side, pick, site, row;
    bit wide;
    logic [CMD_W-1:0] c;
    settle();
    write_reg(ising_pkg::REG_SIDE, CFG_DATA_W'(side_cfg));
    write_reg(ising_pkg::REG_FOUR, four);
    write_reg(ising_pkg::REG_EIGHT, eight);
    side = side_in_use();
    // wide lattices are used only in the two rows at each edge, with no scan
    wide = (side > 16);
    // every site that can be read gets a spin before anything reads it
    for (int i = 0; i < side * side; i++) begin
      row = i / side;
      if (!written_map[i] && (!wide || row < 2 || row >= side - 2)) begin
        pace();
        send_cmd(ising_pkg::CMD_WRITE, SITE_W'(i), 1'($urandom_range(0, 1)), $urandom,
                 1'b0, '0);
      end
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) c = ising_pkg::CMD_FLIP;
      else if (pick < 75) c = ising_pkg::CMD_WRITE;
      else if (pick < 87) c = CMD_OTHER;
      else if (!wide) c = ising_pkg::CMD_MEASURE;
      else c = ising_pkg::CMD_FLIP;
      if (wide) begin
        row = $urandom_range(0, 1) ? 0 : side - 1;
        site = row * side + $urandom_range(0, side - 1);
      end else begin
        site = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NSITES - 1)
                                           : $urandom_range(0, side * side - 1);
      end
      pace();
      send_cmd(c, SITE_W'(site), 1'($urandom_range(0, 1)), pick_uniform(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : res_check
    obs_t got, want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.accepted = res_bus.accepted;
      got.spin_now = res_bus.spin_now;
      got.energy = res_bus.energy;
      got.magnetization = res_bus.magnetization;
      got.right_walls = res_bus.right_walls;
      got.down_walls = res_bus.down_walls;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: acc=%0b spin=%0b E=%0d M=%0d rw=%0d dw=%0d",
                   got.accepted, got.spin_now, got.energy, got.magnetization,
                   got.right_walls, got.down_walls);
      end else begin
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted || got.spin_now !== want.spin_now ||
            got.energy !== want.energy || got.magnetization !== want.magnetization ||
            got.right_walls !== want.right_walls || got.down_walls !== want.down_walls) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected acc=%0b spin=%0b E=%0d M=%0d rw=%0d dw=%0d",
                     want.accepted, want.spin_now, want.energy, want.magnetization,
                     want.right_walls, want.down_walls);
            $display("                 actual   acc=%0b spin=%0b E=%0d M=%0d rw=%0d dw=%0d",
                     got.accepted, got.spin_now, got.energy, got.magnetization,
                     got.right_walls, got.down_walls);
          end
        end
      end
    end
  end

  initial begin : rx_stall
    int  stall_left;
    int  mode_left;
    bit  calm;
    stall_left = 0;
    mode_left = 0;
    calm = 1'b0;
    res_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
        if (mode_left == 0) begin
          calm = !calm;
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  initial begin
    #100ms;
    $display("tb failed");
    $finish;
  end

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.command = ising_pkg::CMD_WRITE;
    cmd_bus.site = '0;
    cmd_bus.spin_value = 1'b0;
    cmd_bus.uniform = '0;
    cfg_we = 1'b0;
    cfg_idx = ising_pkg::REG_SIDE;
    cfg_data = '0;
    rst_n = 1'b0;
    side_reg = ising_pkg::SIDE_RESET;
    level_four = '0;
    level_eight = '0;
    energy_acc = '0;
    mag_acc = '0;
    rwall_acc = '0;
    dwall_acc = '0;
    foreach (lattice_bits[i]) begin
      lattice_bits[i] = 1'b0;
      written_map[i] = 1'b0;
    end

    // reset settings, full lattice
    stim_rows.push_back(fixed_row(ising_pkg::CMD_WRITE, 0, 1'b1, '0, 1'b1));
    stim_rows.push_back(fixed_row(ising_pkg::CMD_WRITE, NSITES - 1, 1'b0, '1, 1'b0));
    stim_rows.push_back(fixed_row(CMD_OTHER, 0, 1'b0, '1, 1'b1));
    stim_rows.push_back(fixed_row(CMD_OTHER, NSITES - 1, 1'b1, '0, 1'b0));
    // smallest lattice, sites past the end are ignored
    stim_rows.push_back(reg_row(ising_pkg::REG_SIDE, 32'd2));
    stim_rows.push_back(fixed_row(ising_pkg::CMD_WRITE, 1, 1'b0, '0, 1'b0));
    stim_rows.push_back(fixed_row(ising_pkg::CMD_WRITE, 2, 1'b0, '0, 1'b0));
    stim_rows.push_back(fixed_row(ising_pkg::CMD_WRITE, 3, 1'b1, '0, 1'b1));
    stim_rows.push_back(fixed_row(ising_pkg::CMD_WRITE, 4, 1'b1, '0, 1'b0));
    stim_rows.push_back(fixed_row(ising_pkg::CMD_FLIP, NSITES - 1, 1'b1, '0, 1'b0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_MEASURE, 4, 1'b0, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_FLIP, 0, 1'b0, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_FLIP, 0, 1'b1, '0));
    stim_rows.push_back(cmd_row(CMD_OTHER, 3, 1'b0, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_MEASURE, 3, 1'b1, '1));
    // odd side, both uphill levels set
    stim_rows.push_back(reg_row(ising_pkg::REG_SIDE, 32'd3));
    stim_rows.push_back(reg_row(ising_pkg::REG_FOUR, '1));
    stim_rows.push_back(reg_row(ising_pkg::REG_EIGHT, 32'h8000_0000));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_WRITE, 4, 1'b1, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_WRITE, 5, 1'b0, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_WRITE, 6, 1'b1, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_WRITE, 7, 1'b1, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_WRITE, 8, 1'b0, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_FLIP, 4, 1'b0, '1));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_FLIP, 1, 1'b0, '0));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_FLIP, 8, 1'b0, 32'h7FFF_FFFF));
    stim_rows.push_back(cmd_row(ising_pkg::CMD_MEASURE, 8, 1'b0, '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_reg) begin
        settle();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].word);
      end else begin
        pace();
        send_cmd(stim_rows[i].cmd, stim_rows[i].site, stim_rows[i].spin, stim_rows[i].word,
                 stim_rows[i].fixed, stim_rows[i].want);
      end
    end

    run_phase(0, '1, '1, 100);
    run_phase(3, 32'h8000_0000, 32'h2000_0000, 150);
    run_phase(4, $urandom, $urandom, 150);
    run_phase(5, '0, '0, 100);
    run_phase(8, $urandom, $urandom, 150);
    run_phase(127, '1, '0, 100);
    run_phase(16, $urandom, $urandom, 150);
    run_phase(1, $urandom, $urandom, 60);
    run_phase(64, $urandom, $urandom, 100);
    run_phase(7, '1, '1, 100);
    run_phase(2, 32'h1, 32'h1, 100);

    settle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
